// ===== rtl/crm_pkg.sv =====
// ---------------------------------------------------------------------------
// Rotation matrix core package
// Shared types, status and operation codes, fixed-point constants and the
// arctangent table of the sine and cosine iteration.
// ---------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

   // Field widths of the item and result channels
   localparam int IDX_W   = 10;
   localparam int COORD_W = 32;
   localparam int ANGLE_W = 19;
   localparam int MAT_W   = 18;

   // Operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_ROTATE = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_ZERO  = 2'd2;

   // Fixed-point constants
   localparam logic signed [MAT_W-1:0] ONE_Q16     = 18'sd65536;
   localparam logic signed [34:0]      HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0]      PI_Q30      = 35'sd3373259426;
   localparam logic signed [33:0]      GAIN_Q30    = 34'sd652032874;

   // Last iteration indices of the sequencer
   localparam logic [4:0] CORDIC_LAST = 5'd29;
   localparam logic [4:0] SQRT_LAST   = 5'd31;
   localparam logic [4:0] DIV_LAST    = 5'd16;
   localparam logic [1:0] AXIS_LAST   = 2'd2;
   localparam logic [3:0] ENTRY_LAST  = 4'd8;
   localparam logic [1:0] PHASE_LAST  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_START,
      S_DIFF,
      S_MAX,
      S_NORM,
      S_SQ,
      S_SQRT,
      S_DIV_INIT,
      S_DIV,
      S_COR_INIT,
      S_COR,
      S_COR_END,
      S_MAT,
      S_DONE
   } state_type;

   // Arctangent of 2^-step in Q30
   function automatic logic [31:0] atan_q30(input logic [4:0] step);
      case (step)
         5'd0:    return 32'd843314857;
         5'd1:    return 32'd497837829;
         5'd2:    return 32'd263043837;
         5'd3:    return 32'd133525159;
         5'd4:    return 32'd67021687;
         5'd5:    return 32'd33543516;
         5'd6:    return 32'd16775851;
         5'd7:    return 32'd8388437;
         5'd8:    return 32'd4194283;
         5'd9:    return 32'd2097149;
         default: return 32'd1 << (5'd30 - step);
      endcase
   endfunction

   // Clamp to [-1.0, +1.0] in Q16
   function automatic logic signed [MAT_W-1:0] sat_q16(input logic signed [31:0] val);
      if (val > 32'sd65536) begin
         return ONE_Q16;
      end else if (val < -32'sd65536) begin
         return -ONE_Q16;
      end
      return MAT_W'(val);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/crankshaft_rotation_matrix_core.sv =====
// ---------------------------------------------------------------------------
// Crankshaft rotation matrix core
// Holds a store of chain vertices and builds the axis-angle rotation matrix
// about the axis between two stored vertices.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A write item
//   stores one vertex; busy stays low, so writes may follow
//   back to back. A rotate item raises busy until its result is out.
//   The result shows on the rsp_ ports for one cycle with rsp_valid high;
//   the receiver cannot stall it, and the next item may be taken in that
//   same cycle.
//   A rotate item normalizes the axis with n (0 to 30) one-bit shifts,
//   then runs 32 square root steps, 3 divides, 30 CORDIC steps and the
//   nine matrix entries. The squares and the matrix products share one
//   multiplier; square root, divide and CORDIC have their own logic.
//   An end index above last_index reports straight from idle, a
//   zero-length axis once the largest magnitude has been found.
//   csr_last_index is written when csr_valid is high (csr_ready is always
//   high); write it only while the core is idle.
//   Reset returns the sequencer to idle and last_index to 1023; the vertex
//   store is not cleared and holds nothing useful until written.
// ---------------------------------------------------------------------------
`default_nettype none

module crankshaft_rotation_matrix_core import crm_pkg::*; #(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // item channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_operation,
   input  wire logic        [IDX_W-1:0]     req_vertex_index,
   input  wire logic signed [COORD_W-1:0]   req_vertex_x,
   input  wire logic signed [COORD_W-1:0]   req_vertex_y,
   input  wire logic signed [COORD_W-1:0]   req_vertex_z,
   input  wire logic        [IDX_W-1:0]     req_axis_start_index,
   input  wire logic        [IDX_W-1:0]     req_axis_end_index,
   input  wire logic signed [ANGLE_W-1:0]   req_rotation_angle,
   // result channel
   output logic                             rsp_valid,
   output logic signed [MAT_W-1:0]          rsp_m00,
   output logic signed [MAT_W-1:0]          rsp_m01,
   output logic signed [MAT_W-1:0]          rsp_m02,
   output logic signed [MAT_W-1:0]          rsp_m10,
   output logic signed [MAT_W-1:0]          rsp_m11,
   output logic signed [MAT_W-1:0]          rsp_m12,
   output logic signed [MAT_W-1:0]          rsp_m20,
   output logic signed [MAT_W-1:0]          rsp_m21,
   output logic signed [MAT_W-1:0]          rsp_m22,
   output logic        [1:0]                rsp_status,
   // configuration
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic        [IDX_W-1:0]     csr_last_index
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int DATA_W = 3 * COORD_W;

   // Reduce an index modulo the store depth by shifted subtraction
   function automatic logic [ADDR_W-1:0] wrap_index(input logic [IDX_W-1:0] idx);
      int rem;
      rem = int'(idx);
      for (int k = IDX_W - 1; k >= 0; k--) begin
         if ((MAX_POINTS << k) < (1 << IDX_W) && rem >= (MAX_POINTS << k)) begin
            rem = rem - (MAX_POINTS << k);
         end
      end
      return ADDR_W'(rem);
   endfunction

   // Sequencer and datapath registers
   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             last_index_ff;
   logic [ADDR_W-1:0]            start_idx_ff, start_idx_in;
   logic signed [ANGLE_W-1:0]    angle_ff, angle_in;
   logic signed [COORD_W-1:0]    end_ff [3];
   logic signed [COORD_W-1:0]    end_in [3];
   logic [32:0]                  mag_ff [3];
   logic [32:0]                  mag_in [3];
   logic                         neg_ff [3];
   logic                         neg_in [3];
   logic [32:0]                  mx_ff, mx_in;
   logic [63:0]                  acc_ff, acc_in;
   logic [34:0]                  srem_ff, srem_in;
   logic [31:0]                  root_ff, root_in;
   logic [48:0]                  drem_ff, drem_in;
   logic [48:0]                  dsr_ff, dsr_in;
   logic [16:0]                  quo_ff, quo_in;
   logic signed [MAT_W-1:0]      v_ff [3];
   logic signed [MAT_W-1:0]      v_in [3];
   logic signed [33:0]           cx_ff, cx_in, cy_ff, cy_in;
   logic signed [34:0]           cz_ff, cz_in;
   logic                         cneg_ff, cneg_in;
   logic signed [MAT_W-1:0]      cos_ff, cos_in, sin_ff, sin_in;
   logic signed [33:0]           p_ff, p_in;
   logic signed [MAT_W-1:0]      mat_ff [9];
   logic signed [MAT_W-1:0]      mat_in [9];
   logic [1:0]                   status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [1:0]                   comp_ff, comp_in;
   logic [3:0]                   entry_ff, entry_in;
   logic [1:0]                   phase_ff, phase_in;

   // Store port signals
   logic                         wr_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [DATA_W-1:0]            rd_data;
   logic signed [COORD_W-1:0]    rd_vec [3];

   // Shared multiplier
   logic signed [33:0]           mul_a;
   logic signed [31:0]           mul_b;
   logic signed [65:0]           prod;

   // Step helpers
   logic signed [32:0]           diff [3];
   logic [32:0]                  mx_cmp;
   logic [34:0]                  sq_rem;
   logic [34:0]                  sq_trial;
   logic                         div_bit;
   logic [16:0]                  q_next;
   logic [16:0]                  q_sat;
   logic signed [34:0]           z_start;
   logic signed [34:0]           atan_step;
   logic signed [33:0]           cor_dx, cor_dy;
   logic signed [33:0]           x_fin, y_fin;
   logic signed [MAT_W-1:0]      vi, vj, kval;
   logic                         diag;
   logic signed [MAT_W:0]        omc;
   logic signed [63:0]           mat_sum;
   logic signed [63:0]           mat_rnd;

   crm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_vertex_index)),
      .wr_data ({req_vertex_z, req_vertex_y, req_vertex_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Store a vertex straight from the item ports; drop writes past the end
   assign wr_en = (state_ff == S_IDLE) && start && (req_operation == OP_WRITE)
                  && (int'(req_vertex_index) < MAX_POINTS);
   assign rd_addr = (state_ff == S_IDLE) ? wrap_index(req_axis_end_index) : start_idx_ff;

   assign rd_vec[0] = rd_data[COORD_W-1:0];
   assign rd_vec[1] = rd_data[2*COORD_W-1:COORD_W];
   assign rd_vec[2] = rd_data[3*COORD_W-1:2*COORD_W];

   // Axis components and their largest magnitude
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = 33'(end_ff[k]) - 33'(rd_vec[k]);
      end
      mx_cmp = mag_ff[0];
      if (mag_ff[1] > mx_cmp) begin
         mx_cmp = mag_ff[1];
      end
      if (mag_ff[2] > mx_cmp) begin
         mx_cmp = mag_ff[2];
      end
   end

   // Square root step: bring down two radicand bits, try the next root bit
   assign sq_rem   = {srem_ff[32:0], acc_ff[63:62]};
   assign sq_trial = {1'b0, root_ff, 2'b01};

   // Divide step: one quotient bit per cycle
   assign div_bit = (drem_ff >= dsr_ff);
   assign q_next  = {quo_ff[15:0], div_bit};
   assign q_sat   = (q_next > 17'd65536) ? 17'd65536 : q_next;

   // CORDIC: angle in Q30 and one rotation step
   assign z_start   = {{2{angle_ff[ANGLE_W-1]}}, angle_ff, 14'b0};
   assign atan_step = $signed(35'(atan_q30(cnt_ff)));
   assign cor_dx    = cy_ff >>> cnt_ff;
   assign cor_dy    = cx_ff >>> cnt_ff;
   assign x_fin     = cneg_ff ? -cx_ff : cx_ff;
   assign y_fin     = cneg_ff ? -cy_ff : cy_ff;

   // Matrix entry operands: outer product pair, skew term, diagonal flag
   always_comb begin
      vi   = v_ff[0];
      vj   = v_ff[0];
      kval = '0;
      diag = 1'b0;
      case (entry_ff)
         4'd0: begin vi = v_ff[0]; vj = v_ff[0]; kval = '0;       diag = 1'b1; end
         4'd1: begin vi = v_ff[0]; vj = v_ff[1]; kval = v_ff[2];               end
         4'd2: begin vi = v_ff[0]; vj = v_ff[2]; kval = -v_ff[1];              end
         4'd3: begin vi = v_ff[1]; vj = v_ff[0]; kval = -v_ff[2];              end
         4'd4: begin vi = v_ff[1]; vj = v_ff[1]; kval = '0;       diag = 1'b1; end
         4'd5: begin vi = v_ff[1]; vj = v_ff[2]; kval = v_ff[0];               end
         4'd6: begin vi = v_ff[2]; vj = v_ff[0]; kval = v_ff[1];               end
         4'd7: begin vi = v_ff[2]; vj = v_ff[1]; kval = -v_ff[0];              end
         4'd8: begin vi = v_ff[2]; vj = v_ff[2]; kval = '0;       diag = 1'b1; end
         default: begin vi = '0; vj = '0; kval = '0; diag = 1'b0; end
      endcase
   end

   assign omc = (MAT_W + 1)'(ONE_Q16) - (MAT_W + 1)'(cos_ff);

   // Select the shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            mul_a = {3'b0, mag_ff[comp_ff][30:0]};
            mul_b = {1'b0, mag_ff[comp_ff][30:0]};
         end
         S_MAT: begin
            case (phase_ff)
               2'd0: begin
                  mul_a = 34'(vi);
                  mul_b = 32'(vj);
               end
               2'd1: begin
                  mul_a = p_ff;
                  mul_b = 32'(omc);
               end
               2'd2: begin
                  mul_a = 34'(sin_ff);
                  mul_b = 32'(kval);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Accumulate skew and diagonal terms, then round Q48 to Q16
   assign mat_sum = $signed(acc_ff) + ($signed(prod[63:0]) <<< 16)
                    + (diag ? (64'(cos_ff) <<< 32) : 64'sd0);
   assign mat_rnd = ($signed(acc_ff) + 64'sd2147483648) >>> 32;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      start_idx_in = start_idx_ff;
      angle_in     = angle_ff;
      end_in       = end_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mx_in        = mx_ff;
      acc_in       = acc_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      drem_in      = drem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      v_in         = v_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cneg_in      = cneg_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      p_in         = p_ff;
      mat_in       = mat_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      entry_in     = entry_ff;
      phase_in     = phase_ff;

      case (state_ff)
         // Take a rotate item; the end vertex read is already under way
         S_IDLE: begin
            if (start && req_operation == OP_ROTATE) begin
               start_idx_in = wrap_index(req_axis_start_index);
               angle_in     = req_rotation_angle;
               status_in    = STATUS_OK;
               for (int k = 0; k < 9; k++) begin
                  mat_in[k] = '0;
               end
               if (req_axis_end_index > last_index_ff) begin
                  status_in = STATUS_RANGE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_RD_START;
               end
            end
         end
         // Hold the end vertex while the start vertex is read
         S_RD_START: begin
            end_in   = rd_vec;
            state_in = S_DIFF;
         end
         // Split the axis into sign and magnitude
         S_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               neg_in[k] = diff[k][32];
               mag_in[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
            end
            state_in = S_MAX;
         end
         S_MAX: begin
            if (mx_cmp == '0) begin
               status_in = STATUS_ZERO;
               state_in  = S_DONE;
            end else begin
               mx_in    = mx_cmp;
               state_in = S_NORM;
            end
         end
         // Shift one bit a cycle until the largest lies in [2^30, 2^31)
         S_NORM: begin
            if (mx_ff[32:31] != 2'b00) begin
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = mag_ff[k] >> 1;
               end
               mx_in = mx_ff >> 1;
            end else if (!mx_ff[30]) begin
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = mag_ff[k] << 1;
               end
               mx_in = mx_ff << 1;
            end else begin
               acc_in   = '0;
               comp_in  = '0;
               state_in = S_SQ;
            end
         end
         // Sum the squares, one component a cycle
         S_SQ: begin
            acc_in  = acc_ff + prod[63:0];
            comp_in = comp_ff + 2'd1;
            if (comp_ff == AXIS_LAST) begin
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            acc_in = acc_ff << 2;
            if (sq_rem >= sq_trial) begin
               srem_in = sq_rem - sq_trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = sq_rem;
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               comp_in  = '0;
               state_in = S_DIV_INIT;
            end
         end
         // Load magnitude * 2^16 + r/2 against r * 2^16
         S_DIV_INIT: begin
            drem_in  = 49'({mag_ff[comp_ff][30:0], 16'b0}) + 49'(root_ff >> 1);
            dsr_in   = {1'b0, root_ff, 16'b0};
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_bit) begin
               drem_in = drem_ff - dsr_ff;
            end
            dsr_in = dsr_ff >> 1;
            quo_in = q_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               v_in[comp_ff] = neg_ff[comp_ff] ? -$signed({1'b0, q_sat})
                                               : $signed({1'b0, q_sat});
               comp_in = comp_ff + 2'd1;
               if (comp_ff == AXIS_LAST) begin
                  state_in = S_COR_INIT;
               end else begin
                  state_in = S_DIV_INIT;
               end
            end
         end
         // Fold the angle into [-pi/2, pi/2]
         S_COR_INIT: begin
            cx_in   = GAIN_Q30;
            cy_in   = '0;
            cnt_in  = '0;
            if (z_start > HALF_PI_Q30) begin
               cz_in   = z_start - PI_Q30;
               cneg_in = 1'b1;
            end else if (z_start < -HALF_PI_Q30) begin
               cz_in   = z_start + PI_Q30;
               cneg_in = 1'b1;
            end else begin
               cz_in   = z_start;
               cneg_in = 1'b0;
            end
            state_in = S_COR;
         end
         S_COR: begin
            if (!cz_ff[34]) begin
               cx_in = cx_ff - cor_dx;
               cy_in = cy_ff + cor_dy;
               cz_in = cz_ff - atan_step;
            end else begin
               cx_in = cx_ff + cor_dx;
               cy_in = cy_ff - cor_dy;
               cz_in = cz_ff + atan_step;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CORDIC_LAST) begin
               state_in = S_COR_END;
            end
         end
         // Round Q30 to Q16
         S_COR_END: begin
            cos_in   = sat_q16(32'((x_fin + 34'sd8192) >>> 14));
            sin_in   = sat_q16(32'((y_fin + 34'sd8192) >>> 14));
            entry_in = '0;
            phase_in = '0;
            state_in = S_MAT;
         end
         // Four phases per entry: vi*vj, *(1-c), +s*k and c, round
         S_MAT: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               2'd0: p_in   = prod[33:0];
               2'd1: acc_in = prod[63:0];
               2'd2: acc_in = mat_sum;
               default: begin
                  mat_in[entry_ff] = sat_q16(32'(mat_rnd));
               end
            endcase
            if (phase_ff == PHASE_LAST) begin
               entry_in = entry_ff + 4'd1;
               if (entry_ff == ENTRY_LAST) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_index_ff <= 10'd1023;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            last_index_ff <= csr_last_index;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      start_idx_ff <= start_idx_in;
      angle_ff     <= angle_in;
      end_ff       <= end_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      mx_ff        <= mx_in;
      acc_ff       <= acc_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      drem_ff      <= drem_in;
      dsr_ff       <= dsr_in;
      quo_ff       <= quo_in;
      v_ff         <= v_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      cneg_ff      <= cneg_in;
      cos_ff       <= cos_in;
      sin_ff       <= sin_in;
      p_ff         <= p_in;
      mat_ff       <= mat_in;
      status_ff    <= status_in;
      cnt_ff       <= cnt_in;
      comp_ff      <= comp_in;
      entry_ff     <= entry_in;
      phase_ff     <= phase_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_m00    = mat_ff[0];
   assign rsp_m01    = mat_ff[1];
   assign rsp_m02    = mat_ff[2];
   assign rsp_m10    = mat_ff[3];
   assign rsp_m11    = mat_ff[4];
   assign rsp_m12    = mat_ff[5];
   assign rsp_m20    = mat_ff[6];
   assign rsp_m21    = mat_ff[7];
   assign rsp_m22    = mat_ff[8];
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

// ===== rtl/crm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module crm_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// Rotation matrix core testbench
// Drives vertex writes and rotate items into the core, predicts each
// matrix and status in fixed point unless the table types it, and
// checks each result in order. Covers a directed table, then random
// bursts over several last_index settings.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import crm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = OP_WRITE;
   logic [IDX_W-1:0] req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_vertex_x = '0, req_vertex_y = '0, req_vertex_z = '0;
   logic [IDX_W-1:0] req_axis_start_index = '0, req_axis_end_index = '0;
   logic signed [ANGLE_W-1:0] req_rotation_angle = '0;
   logic rsp_valid;
   logic signed [MAT_W-1:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [MAT_W-1:0] rsp_m20, rsp_m21, rsp_m22;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_last_index = '0;

   typedef struct packed {
      logic                      op;
      logic [IDX_W-1:0]          vidx;
      logic signed [COORD_W-1:0] x, y, z;
      logic [IDX_W-1:0]          s_idx, e_idx;
      logic signed [ANGLE_W-1:0] ang;
   } item_type;

   typedef struct {
      logic signed [MAT_W-1:0] m [9];
      logic [1:0]              status;
   } matrix_type;

   typedef struct {
      item_type   it;
      logic       known;   // expected value typed in the table
      matrix_type want;
   } row_type;

   matrix_type matrix_queue[$];
   int errors = 0;
   int n_rot = 0;
   int n_wr = 0;

   // predictor state
   logic signed [31:0] px[NPTS], py[NPTS], pz[NPTS];
   bit written[NPTS];
   logic [IDX_W-1:0] pred_last = 10'd1023;

   always #1 clock = ~clock;

   crankshaft_rotation_matrix_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_vertex_index(req_vertex_index),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z), .req_axis_start_index(req_axis_start_index),
      .req_axis_end_index(req_axis_end_index), .req_rotation_angle(req_rotation_angle),
      .rsp_valid(rsp_valid), .rsp_m00(rsp_m00), .rsp_m01(rsp_m01), .rsp_m02(rsp_m02),
      .rsp_m10(rsp_m10), .rsp_m11(rsp_m11), .rsp_m12(rsp_m12), .rsp_m20(rsp_m20),
      .rsp_m21(rsp_m21), .rsp_m22(rsp_m22), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_last_index(csr_last_index));

   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp_q16(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic longint root64(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // sine and cosine of a Q3.16 angle, Q16 out
   function automatic void sin_cos(input longint a, output longint s, output longint c);
      longint z, x, y, dx, dy, t;
      bit neg;
      longint atan_tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149};
      z = a * 16384;
      x = 652032874;
      y = 0;
      neg = 0;
      if (z > 1686629713) begin
         z -= 64'sd3373259426; neg = 1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426; neg = 1;
      end
      for (int i = 0; i < 30; i++) begin
         dx = fshr(y, i);
         dy = fshr(x, i);
         t = (i < 10) ? atan_tab[i] : (longint'(1) << (30 - i));
         if (z >= 0) begin
            x -= dx; y += dy; z -= t;
         end else begin
            x += dx; y -= dy; z += t;
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = clamp_q16(fshr(x + 8192, 14));
      s = clamp_q16(fshr(y + 8192, 14));
   endfunction

   // apply one item to the vertex store and work out its matrix, if any
   function automatic bit rotation_of(item_type it, output matrix_type r);
      longint d[3], v[3], kq[9], acc, s, c, u;
      longint unsigned mag[3], mx, sum, rt;
      int ms, ne;
      for (int k = 0; k < 9; k++) r.m[k] = '0;
      r.status = STATUS_OK;
      if (it.op == OP_WRITE) begin
         px[it.vidx] = it.x; py[it.vidx] = it.y; pz[it.vidx] = it.z;
         written[it.vidx] = 1;
         return 0;
      end
      ms = int'(it.s_idx);
      ne = int'(it.e_idx);
      if (ne > pred_last) begin
         r.status = STATUS_RANGE;
         return 1;
      end
      d[0] = longint'(px[ne]) - longint'(px[ms]);
      d[1] = longint'(py[ne]) - longint'(py[ms]);
      d[2] = longint'(pz[ne]) - longint'(pz[ms]);
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (d[i] < 0) ? -d[i] : d[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         r.status = STATUS_ZERO;
         return 1;
      end
      while (mx >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
         mx <<= 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      rt = root64(sum);
      for (int i = 0; i < 3; i++) begin
         u = longint'((mag[i] * 64'd65536 + rt / 2) / rt);
         if (u > 65536) u = 65536;
         v[i] = (d[i] < 0) ? -u : u;
      end
      sin_cos(longint'(it.ang), s, c);
      kq = '{0, v[2], -v[1], -v[2], 0, v[0], v[1], -v[0], 0};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = (v[i] * v[j]) * (65536 - c);
            acc += (s * kq[i*3+j]) * 65536;
            if (i == j) acc += c * 64'sd4294967296;
            r.m[i*3+j] = MAT_W'(clamp_q16(fshr(acc + 64'sd2147483648, 32)));
         end
      end
      return 1;
   endfunction

   // check each strobed result against the oldest expectation
   always @(posedge clock) begin
      matrix_type w;
      logic signed [MAT_W-1:0] got [9];
      if (!reset && rsp_valid) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (matrix_queue.size() == 0) begin
            $error("unexpected result, status %0d", rsp_status);
            errors++;
         end else begin
            w = matrix_queue.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               errors++;
            end
            for (int k = 0; k < 9; k++) begin
               if (got[k] !== w.m[k]) begin
                  $error("m%0d%0d: expected %0d, got %0d", k / 3, k % 3, w.m[k], got[k]);
                  errors++;
               end
            end
         end
      end
   end

   // send one item; a typed expectation overrides the predicted one
   task automatic send_item(item_type it, bit known, matrix_type want);
      matrix_type pred;
      bit has;
      start <= 1'b1;
      req_operation <= it.op;
      req_vertex_index <= it.vidx;
      req_vertex_x <= it.x;
      req_vertex_y <= it.y;
      req_vertex_z <= it.z;
      req_axis_start_index <= it.s_idx;
      req_axis_end_index <= it.e_idx;
      req_rotation_angle <= it.ang;
      do @(posedge clock); while (busy);
      has = rotation_of(it, pred);
      if (has) begin
         matrix_queue.push_back(known ? want : pred);
         n_rot++;
      end else begin
         n_wr++;
      end
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (matrix_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic set_last(logic [IDX_W-1:0] val);
      csr_valid <= 1'b1;
      csr_last_index <= val;
      do @(posedge clock); while (!csr_ready);
      pred_last = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic item_type wr(int idx, int x, int y, int z);
      item_type it;
      it = '0;
      it.op = OP_WRITE; it.vidx = IDX_W'(idx); it.x = x; it.y = y; it.z = z;
      return it;
   endfunction

   function automatic item_type rot(int si, int ei, int ang);
      item_type it;
      it = '0;
      it.op = OP_ROTATE; it.s_idx = IDX_W'(si); it.e_idx = IDX_W'(ei);
      it.ang = ANGLE_W'(ang);
      return it;
   endfunction

   function automatic item_type random_item(int hi);
      item_type it;
      int si, ei;
      it = '0;
      it.x = $urandom; it.y = $urandom; it.z = $urandom;
      it.ang = ANGLE_W'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         it.op = OP_WRITE;
         it.vidx = IDX_W'($urandom_range(0, hi));
         if ($urandom_range(0, 5) == 0) it.x = $urandom_range(0, 3) - 2;
         if ($urandom_range(0, 5) == 0) it.y = 0;
         if ($urandom_range(0, 9) == 0) it.ang = 0;
      end else begin
         it.op = OP_ROTATE;
         // pick written vertices; an end past the limit needs no read
         do si = $urandom_range(0, hi); while (!written[si]);
         if ($urandom_range(0, 9) == 0) begin
            ei = $urandom_range(0, NPTS - 1);
            if (ei <= pred_last && !written[ei]) ei = si;
         end else if ($urandom_range(0, 15) == 0) begin
            ei = si;
         end else begin
            do ei = $urandom_range(0, hi); while (!written[ei]);
         end
         it.s_idx = IDX_W'(si); it.e_idx = IDX_W'(ei);
         if ($urandom_range(0, 7) == 0)
            it.ang = $urandom_range(0, 1) ? 19'sh3FFFF : -19'sh40000;
      end
      return it;
   endfunction

   // directed table
   row_type rows[$];
   matrix_type zm;

   initial begin
      matrix_type rng, zer;
      int limits[4] = '{5, 1023, 37, 200};
      int hi;
      for (int k = 0; k < 9; k++) zm.m[k] = '0;
      zm.status = STATUS_OK;
      rng = zm; rng.status = STATUS_RANGE;
      zer = zm; zer.status = STATUS_ZERO;

      rows.push_back('{wr(0, 0, 0, 0), 0, zm});
      rows.push_back('{wr(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF), 0, zm});
      rows.push_back('{wr(2, 32'sh80000000, 32'sh80000000, 32'sh80000000), 0, zm});
      rows.push_back('{wr(3, 65536, 0, 0), 0, zm});
      rows.push_back('{wr(4, 0, 0, 1), 0, zm});
      rows.push_back('{wr(1023, -1, 32'sh7FFFFFFF, 32'sh80000000), 0, zm});
      rows.push_back('{wr(5, 0, 0, 0), 0, zm});
      rows.push_back('{rot(0, 5, 1000), 1, zer});
      rows.push_back('{rot(0, 0, 0), 1, zer});
      rows.push_back('{rot(0, 3, 0), 0, zm});
      rows.push_back('{rot(0, 4, 102944), 0, zm});
      rows.push_back('{rot(0, 4, -102944), 0, zm});
      rows.push_back('{rot(1, 2, 205887), 0, zm});
      rows.push_back('{rot(2, 1, -205887), 0, zm});
      rows.push_back('{rot(0, 1, 19'sh3FFFF), 0, zm});
      rows.push_back('{rot(0, 1023, -19'sh40000), 0, zm});
      rows.push_back('{rot(1023, 2, 51472), 0, zm});
      rows.push_back('{rot(900, 3, 1), 0, zm});

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      // untouched start index 900 is first written to avoid an unwritten read
      rows.insert(0, '{wr(900, 7, -7, 70000), 0, zm});

      // walk the table at reset last_index
      foreach (rows[i]) send_item(rows[i].it, rows[i].known, rows[i].want);
      drain();
      set_last(10'd5);
      send_item(rot(0, 6, 0), 1, rng);
      // end too large and zero-length together: the range check wins
      send_item(rot(1023, 1023, 0), 1, rng);
      send_item(rot(0, 5, 0), 1, zer);
      drain();

      // random phases over several last_index settings
      foreach (limits[p]) begin
         set_last(IDX_W'(limits[p]));
         hi = (p == 1) ? 1023 : limits[p] + 3;
         for (int n = 0; n < 200; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 200; b++, n++) begin
               item_type it;
               it = random_item(hi);
               send_item(it, 0, zm);
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 40));
         end
         drain();
      end

      $display("covered %0d vertex writes and %0d rotate items", n_wr, n_rot);
      $display("last_index settings 1023, 5, 37, 200 with bursty stimulus");
      if (errors == 0 && matrix_queue.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

   // clear the written flags; the table writes vertex 0 first, so rotate picks never spin
   initial begin
      for (int i = 0; i < NPTS; i++) written[i] = 0;
   end

endmodule

`default_nettype wire
